// ===== sv/bba_pkg.sv =====
// Shared constants and types for the block bitmap allocator.
`default_nettype none
package bba_pkg;

	localparam int unsigned MAX_BLOCKS = 65536;
	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned MAP_DEPTH  = MAX_BLOCKS / WORD_BITS;
	localparam int unsigned IDX_W      = $clog2(MAP_DEPTH);
	localparam int unsigned BIT_W      = $clog2(WORD_BITS);
	localparam int unsigned BLK_W      = 16;
	localparam int unsigned CNT_W      = 17;

	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] BLK_LIMIT = CNT_W'(MAX_BLOCKS);

	// request kinds
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	// result status
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_RANGE  = 2'd2;
	localparam logic [1:0] STAT_ALFREE = 2'd3;

	// register indexes
	localparam logic [1:0] REG_FIRST_DATA  = 2'd0;
	localparam logic [1:0] REG_TOTAL_COUNT = 2'd1;
	localparam logic [1:0] REG_INIT_FREE   = 2'd2;

	typedef struct packed {
		logic [BLK_W-1:0] granted;
		logic [1:0]       status;
		logic [CNT_W-1:0] free_blocks;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/block_bitmap_allocator_top.sv =====
// First-fit bitmap block allocator: usage map memory, scan sequencer and free counter.
// Load completes directly; free reads the map word, checks the bit, writes it back and
// completes (no write when already free, no check when out of range); allocate scans one
// map word per cycle (up to 2048 words), then writes the grant, or completes as full.
// An empty window completes as full with no scan. One request at a time; a stalled result
// holds the next one off. Reset clears all 2048 map words; config always taken.
`default_nettype none
module block_bitmap_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] block_number, [26:16] word_index, [58:27] word_bits
	input  wire logic [63:0] s_axis_tdata,
	// [1:0] op
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [15:0] granted_block, [32:16] free_blocks
	output logic [39:0]      m_axis_tdata,
	// [1:0] status
	output logic [1:0]       m_axis_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);

	localparam int unsigned IW = bba_pkg::IDX_W;
	localparam int unsigned BW = bba_pkg::BIT_W;
	localparam int unsigned WB = bba_pkg::WORD_BITS;
	localparam int unsigned KW = bba_pkg::BLK_W;
	localparam int unsigned CW = bba_pkg::CNT_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FCHK  = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]    state_q;
	logic [IW-1:0] clr_q;
	logic [KW-1:0] first_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] free_q;

	logic [IW-1:0] scan_q;
	logic          issue_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_word_s1;
	logic [KW-1:0] blk_q;
	logic [IW-1:0] wr_addr_q;
	logic [WB-1:0] wr_data_q;
	logic          wr_inc_q;
	logic [KW-1:0] res_grant_q;
	logic [1:0]    res_stat_q;
	logic          m_valid_q;
	bba_pkg::res_t out_q;

	logic [WB-1:0] map_mem [bba_pkg::MAP_DEPTH];
	logic [WB-1:0] mem_rdata;
	logic          mem_re, mem_we;
	logic [IW-1:0] mem_raddr, mem_waddr;
	logic [WB-1:0] mem_wdata;

	logic          accept;
	logic [1:0]    in_op;
	logic [KW-1:0] in_blk;
	logic [IW-1:0] in_widx;
	logic [WB-1:0] in_bits;
	logic [CW-1:0] lim;
	logic [KW-1:0] lim_m1;
	logic [IW-1:0] wfirst, wlast;
	logic [WB-1:0] cand;
	logic          cand_any;
	logic [BW-1:0] hit_idx;
	logic [WB-1:0] hit_bit;
	logic [WB-1:0] free_bit;

	assign in_op   = s_axis_tuser;
	assign in_blk  = s_axis_tdata[15:0];
	assign in_widx = s_axis_tdata[26:16];
	assign in_bits = s_axis_tdata[58:27];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign lim    = (total_q > bba_pkg::BLK_LIMIT) ? bba_pkg::BLK_LIMIT : total_q;
	assign lim_m1 = KW'(lim - CW'(1));
	assign wfirst = first_q[KW-1:BW];
	assign wlast  = lim_m1[KW-1:BW];

	// window mask on the word now out of the memory, then lowest free bit
	always_comb begin
		cand = ~mem_rdata;
		for (int i = 0; i < WB; i++) begin
			if (rd_word_s1 == wfirst && BW'(i) < first_q[BW-1:0])
				cand[i] = 1'b0;
			if (rd_word_s1 == wlast && BW'(i) > lim_m1[BW-1:0])
				cand[i] = 1'b0;
		end
	end

	assign cand_any = |cand;

	always_comb begin
		hit_idx = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (cand[i])
				hit_idx = BW'(i);
		end
	end

	assign hit_bit  = WB'(1) << hit_idx;
	assign free_bit = WB'(1) << blk_q[BW-1:0];

	// memory ports
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = scan_q;
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = wr_data_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				if (accept && in_op == bba_pkg::OP_FREE) begin
					mem_re    = 1'b1;
					mem_raddr = in_blk[KW-1:BW];
				end
				if (accept && in_op == bba_pkg::OP_LOAD) begin
					mem_we    = 1'b1;
					mem_waddr = in_widx;
					mem_wdata = in_bits;
				end
			end
			ST_SCAN: begin
				mem_re = issue_q;
			end
			ST_WRITE: begin
				mem_we = 1'b1;
			end
			ST_FCHK, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			mem_rdata <= map_mem[mem_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q   <= in_blk;
			scan_q  <= wfirst;
			wr_inc_q <= (in_op == bba_pkg::OP_FREE);
		end else if (state_q == ST_SCAN && issue_q) begin
			scan_q <= scan_q + IW'(1);
		end
		if (state_q == ST_SCAN && issue_q)
			rd_word_s1 <= scan_q;
		if (state_q == ST_SCAN && rd_vld_s1 && cand_any) begin
			wr_addr_q   <= rd_word_s1;
			wr_data_q   <= mem_rdata | hit_bit;
			res_grant_q <= {rd_word_s1, hit_idx};
		end
		if (state_q == ST_FCHK) begin
			wr_addr_q   <= blk_q[KW-1:BW];
			wr_data_q   <= mem_rdata & ~free_bit;
			res_grant_q <= '0;
		end
		if (accept)
			res_grant_q <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			res_stat_q <= bba_pkg::STAT_OK;
			first_q    <= '0;
			total_q    <= bba_pkg::BLK_LIMIT;
			free_q     <= '0;
			m_valid_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			// the completion step reloads the output word itself
			if (m_valid_q && m_axis_tready && state_q != ST_DONE)
				m_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(bba_pkg::MAP_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						issue_q    <= 1'b1;
						rd_vld_s1  <= 1'b0;
						case (in_op)
							bba_pkg::OP_ALLOC: begin
								if ({1'b0, first_q} >= lim) begin
									res_stat_q <= bba_pkg::STAT_FULL;
									state_q    <= ST_DONE;
								end else begin
									res_stat_q <= bba_pkg::STAT_OK;
									state_q    <= ST_SCAN;
								end
							end
							bba_pkg::OP_FREE: begin
								if (in_blk == '0 || {1'b0, in_blk} >= lim) begin
									res_stat_q <= bba_pkg::STAT_RANGE;
									state_q    <= ST_DONE;
								end else begin
									res_stat_q <= bba_pkg::STAT_OK;
									state_q    <= ST_FCHK;
								end
							end
							bba_pkg::OP_LOAD: begin
								res_stat_q <= bba_pkg::STAT_OK;
								state_q    <= ST_DONE;
							end
							default: begin
								res_stat_q <= bba_pkg::STAT_RANGE;
								state_q    <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// reads run one word ahead of the evaluation
					if (rd_vld_s1 && cand_any) begin
						issue_q   <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_WRITE;
					end else if (rd_vld_s1 && rd_word_s1 == wlast) begin
						issue_q    <= 1'b0;
						rd_vld_s1  <= 1'b0;
						res_stat_q <= bba_pkg::STAT_FULL;
						state_q    <= ST_DONE;
					end else begin
						rd_vld_s1 <= issue_q;
						if (issue_q && scan_q == wlast)
							issue_q <= 1'b0;
					end
				end
				ST_FCHK: begin
					if (mem_rdata[blk_q[BW-1:0]]) begin
						state_q <= ST_WRITE;
					end else begin
						res_stat_q <= bba_pkg::STAT_ALFREE;
						state_q    <= ST_DONE;
					end
				end
				ST_WRITE: begin
					if (wr_inc_q) begin
						if (free_q != bba_pkg::CNT_MAX)
							free_q <= free_q + CW'(1);
					end else if (free_q != '0) begin
						free_q <= free_q - CW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						out_q.granted     <= res_grant_q;
						out_q.status      <= res_stat_q;
						out_q.free_blocks <= free_q;
						m_valid_q         <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					bba_pkg::REG_FIRST_DATA:  first_q <= cfg_data[KW-1:0];
					bba_pkg::REG_TOTAL_COUNT: total_q <= cfg_data;
					bba_pkg::REG_INIT_FREE:   free_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, out_q.free_blocks, out_q.granted};
	assign m_axis_tuser  = out_q.status;

`ifndef SYNTHESIS
	// a granted nonzero block lies inside the allocation window
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == bba_pkg::STAT_OK && m_axis_tdata[15:0] != '0)
		|-> ({1'b0, m_axis_tdata[15:0]} < lim && m_axis_tdata[15:0] >= first_q))
		else $error("granted block outside allocation window");

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("request taken while busy");

	// a new result only leaves the completion step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");

	// a map update on allocate or free flips exactly one bit of the word read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> $countones(wr_data_q ^ $past(mem_rdata)) == 1)
		else $error("map update changed more than one bit");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the block bitmap allocator: directed table, then random phases.
`timescale 1ns / 100ps
module tb_top;
	import bba_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	// slowest legal run is well under this: a full 2048-word scan on every request
	// plus stalls and the clearing pass after reset
	localparam int LIMIT_CYCLES = 20000000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_PRINTS   = 30;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// [15:0] block_number, [26:16] word_index, [58:27] word_bits
	logic [63:0]          s_axis_tdata  = '0;
	// [1:0] op
	logic [1:0]           s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// [15:0] granted_block, [32:16] free_blocks
	logic [39:0]          m_axis_tdata;
	// [1:0] status
	logic [1:0]           m_axis_tuser;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index     = '0;
	logic [16:0]          cfg_data      = '0;

	// shadow copy of the allocator state
	logic [WORD_BITS-1:0] shadow_map [MAP_DEPTH];
	logic [CNT_W-1:0]     shadow_free;
	logic [BLK_W-1:0]     first_blk;
	logic [CNT_W-1:0]     blk_total;

	res_t                 answers_due[$];
	int unsigned          grant_log[$];
	res_t                 seen, due;

	bit                   calm        = 1'b0;
	int                   holds_asked = 0;
	int                   errors      = 0;
	int                   cycles      = 0;
	int                   reg_writes  = 0;
	int                   op_tally[4];
	int                   status_tally[4];

	typedef struct {
		bit                   reg_write;
		logic [1:0]           code;   // op, or register index
		logic [16:0]          arg;    // block number, or register value
		logic [IDX_W-1:0]     widx;
		logic [WORD_BITS-1:0] bits;
		bit                   typed;
		res_t                 want;
	} step_t;

	step_t plan[$];

	block_bitmap_allocator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycles, answers_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic res_t ans(input int g, input logic [1:0] s, input int f);
		res_t r;
		r.granted     = BLK_W'(g);
		r.status      = s;
		r.free_blocks = CNT_W'(f);
		return r;
	endfunction

	function automatic void add_req(input logic [1:0] op, input int blk,
		input logic [IDX_W-1:0] widx, input logic [WORD_BITS-1:0] bits,
		input bit typed, input res_t want);
		step_t s;
		s.reg_write = 1'b0;
		s.code      = op;
		s.arg       = 17'(blk);
		s.widx      = widx;
		s.bits      = bits;
		s.typed     = typed;
		s.want      = want;
		plan.push_back(s);
	endfunction

	function automatic void add_reg(input logic [1:0] idx, input int val);
		step_t s;
		s.reg_write = 1'b1;
		s.code      = idx;
		s.arg       = 17'(val);
		s.widx      = '0;
		s.bits      = '0;
		s.typed     = 1'b0;
		s.want      = '0;
		plan.push_back(s);
	endfunction

	function automatic void report(input string what, input longint want, input longint got);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endfunction

	// first-fit allocator answer for one request; updates the shadow state
	function automatic res_t allocator_answer(input logic [1:0] op,
		input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] widx,
		input logic [WORD_BITS-1:0] bits);
		res_t        r;
		int unsigned lim;
		int unsigned b;
		r   = '0;
		lim = (blk_total > BLK_LIMIT) ? MAX_BLOCKS : int'(blk_total);
		case (op)
		OP_ALLOC: begin
			b = 32'(first_blk);
			while (b < lim && shadow_map[b / WORD_BITS][b % WORD_BITS])
				b++;
			if (b < lim) begin
				shadow_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
				if (shadow_free != 0)
					shadow_free--;
				r.granted = BLK_W'(b);
				grant_log.push_back(b);
			end else begin
				r.status = STAT_FULL;
			end
		end
		OP_FREE: begin
			if (blk == 0 || blk >= lim) begin
				r.status = STAT_RANGE;
			end else if (shadow_map[blk / WORD_BITS][blk % WORD_BITS]) begin
				shadow_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
				if (shadow_free != CNT_MAX)
					shadow_free++;
			end else begin
				r.status = STAT_ALFREE;
			end
		end
		OP_LOAD: begin
			if (widx < MAP_DEPTH)
				shadow_map[widx] = bits;
			else
				r.status = STAT_RANGE;
		end
		default: begin
			r.status = STAT_RANGE;
		end
		endcase
		r.free_blocks = shadow_free;
		return r;
	endfunction

	// offer one request word, wait for it to be taken, queue its answer
	task automatic offer_request(input logic [1:0] op, input logic [BLK_W-1:0] blk,
		input logic [IDX_W-1:0] widx, input logic [WORD_BITS-1:0] bits,
		input bit typed, input res_t want);
		res_t r;
		while (!calm && $urandom_range(0, 99) < 25) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, bits, widx, blk};
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = allocator_answer(op, blk, widx, bits);
		answers_due.push_back(typed ? want : r);
		op_tally[op]++;
		status_tally[r.status]++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
		REG_FIRST_DATA:  first_blk   = val[BLK_W-1:0];
		REG_TOTAL_COUNT: blk_total   = val;
		REG_INIT_FREE:   shadow_free = val;
		default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering and wait until every queued answer has come back
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic random_phase(input int n_items, input bit with_hold);
		int                   i, lo, lim, pick, w_lo, w_hi;
		int unsigned          r;
		logic [1:0]           op;
		logic [BLK_W-1:0]     blk;
		logic [IDX_W-1:0]     widx;
		logic [WORD_BITS-1:0] bits;
		lo   = int'(first_blk);
		lim  = (blk_total > BLK_LIMIT) ? MAX_BLOCKS : int'(blk_total);
		w_lo = lo / WORD_BITS;
		w_hi = (lim > lo) ? (lim - 1) / WORD_BITS : w_lo;
		for (i = 0; i < n_items; i++) begin
			// receiver backs off while we keep offering, so the block fills up
			if (with_hold && i == 20)
				holds_asked++;
			blk  = BLK_W'($urandom);
			widx = IDX_W'($urandom);
			bits = $urandom;
			r    = $urandom_range(0, 99);
			if (r < 45) begin
				op = OP_ALLOC;
			end else if (r < 75) begin
				op = OP_FREE;
				r  = $urandom_range(0, 9);
				if (r < 5 && grant_log.size() != 0) begin
					pick = $urandom_range(0, grant_log.size() - 1);
					blk  = BLK_W'(grant_log[pick]);
					grant_log.delete(pick);
				end else if (r < 8 && lim > lo) begin
					blk = BLK_W'($urandom_range(lo, lim - 1));
				end else if (r < 9) begin
					case ($urandom_range(0, 3))
					0: blk = '0;
					1: blk = BLK_W'(lo - 1);
					2: blk = BLK_W'(lim);
					default: blk = '1;
					endcase
				end
			end else if (r < 93) begin
				op = OP_LOAD;
				if ($urandom_range(0, 9) < 7)
					widx = IDX_W'($urandom_range(w_lo, w_hi));
				case ($urandom_range(0, 9))
				0, 1, 2: bits = '1;
				3, 4:    bits = '0;
				default: ;
				endcase
			end else begin
				op = OP_UNUSED;
			end
			offer_request(op, blk, widx, bits, 1'b0, '0);
		end
	endtask

	// result words are checked in order against answers_due
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.granted     = m_axis_tdata[15:0];
			seen.free_blocks = m_axis_tdata[32:16];
			seen.status      = m_axis_tuser;
			if (answers_due.size() == 0) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: unexpected word, granted %0d status %0d free %0d",
						$time, seen.granted, seen.status, seen.free_blocks);
			end else begin
				due = answers_due.pop_front();
				if (seen.granted !== due.granted)
					report("granted_block", due.granted, seen.granted);
				if (seen.status !== due.status)
					report("status", due.status, seen.status);
				if (seen.free_blocks !== due.free_blocks)
					report("free_blocks", due.free_blocks, seen.free_blocks);
			end
		end
	end

	initial begin : result_sink
		int hold_left;
		int holds_done;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	initial begin : stimulus
		int p, k, lo, tot;
		for (k = 0; k < MAP_DEPTH; k++)
			shadow_map[k] = '0;
		for (k = 0; k < 4; k++) begin
			op_tally[k]     = 0;
			status_tally[k] = 0;
		end
		first_blk   = '0;
		blk_total   = BLK_LIMIT;
		shadow_free = '0;

		// defaults after reset: window is the whole map, counter at zero
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(0, STAT_OK, 0));
		add_req(OP_ALLOC, 0, '1, '1, 1, ans(1, STAT_OK, 0));
		add_req(OP_FREE, 0, '0, '0, 1, ans(0, STAT_RANGE, 0));
		add_req(OP_FREE, 1, '0, '0, 1, ans(0, STAT_OK, 1));
		add_req(OP_FREE, 1, '0, '0, 1, ans(0, STAT_ALFREE, 1));
		add_req(OP_UNUSED, 16'hFFFF, '1, '1, 1, ans(0, STAT_RANGE, 1));
		add_req(OP_LOAD, 0, '1, '1, 1, ans(0, STAT_OK, 1));
		add_req(OP_LOAD, 0, '0, '1, 1, ans(0, STAT_OK, 1));
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(32, STAT_OK, 0));
		add_req(OP_FREE, 16'hFFFF, '0, '0, 1, ans(0, STAT_OK, 1));
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(33, STAT_OK, 0));
		// counter at its top saturates on free
		add_reg(REG_INIT_FREE, 17'h1FFFF);
		add_req(OP_FREE, 32, '0, '0, 1, ans(0, STAT_OK, 17'h1FFFF));
		add_reg(REG_INIT_FREE, 65536);
		add_req(OP_FREE, 33, '0, '0, 0, '0);
		add_reg(REG_TOTAL_COUNT, 100);
		add_reg(REG_FIRST_DATA, 40);
		add_req(OP_FREE, 100, '0, '0, 1, ans(0, STAT_RANGE, 65537));
		add_req(OP_FREE, 99, '0, '0, 1, ans(0, STAT_ALFREE, 65537));
		add_req(OP_ALLOC, 0, '0, '0, 0, '0);
		add_req(OP_LOAD, 0, 1, '1, 0, '0);
		add_req(OP_LOAD, 0, 2, '1, 0, '0);
		add_req(OP_LOAD, 0, 3, 32'hF, 0, '0);
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(0, STAT_FULL, 65536));
		// empty window, then no blocks at all
		add_reg(REG_FIRST_DATA, 100);
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(0, STAT_FULL, 65536));
		add_reg(REG_TOTAL_COUNT, 0);
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(0, STAT_FULL, 65536));
		add_req(OP_FREE, 1, '0, '0, 1, ans(0, STAT_RANGE, 65536));
		// total above the map size is clipped to the map
		add_reg(REG_TOTAL_COUNT, 17'h1FFFF);
		add_reg(REG_FIRST_DATA, 65535);
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(65535, STAT_OK, 65535));
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(0, STAT_FULL, 65535));
		add_req(OP_FREE, 65535, '0, '0, 1, ans(0, STAT_OK, 65536));
		add_reg(REG_INIT_FREE, 0);
		add_req(OP_ALLOC, 0, '0, '0, 1, ans(65535, STAT_OK, 0));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].reg_write) begin
				drain();
				write_reg(plan[k].code, plan[k].arg);
			end else begin
				offer_request(plan[k].code, plan[k].arg[BLK_W-1:0], plan[k].widx,
					plan[k].bits, plan[k].typed, plan[k].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			calm <= (p == 3);
			drain();
			if (p == 4) begin
				lo  = 0;
				tot = MAX_BLOCKS;
			end else begin
				case (p % 4)
				1: begin
					tot = MAX_BLOCKS;
					lo  = MAX_BLOCKS - $urandom_range(1, 300);
				end
				2: begin
					lo  = $urandom_range(0, 65000);
					tot = lo + $urandom_range(32, 500);
				end
				default: begin
					lo  = $urandom_range(0, 64);
					tot = lo + $urandom_range(0, 400);
				end
				endcase
			end
			write_reg(REG_FIRST_DATA, 17'(lo));
			write_reg(REG_TOTAL_COUNT, 17'(tot));
			case ($urandom_range(0, 3))
			0: write_reg(REG_INIT_FREE, 17'd0);
			1: write_reg(REG_INIT_FREE, BLK_LIMIT);
			2: write_reg(REG_INIT_FREE, 17'($urandom_range(0, MAX_BLOCKS)));
			default: ;
			endcase
			random_phase(PHASE_ITEMS, p == 1);
		end

		drain();
		repeat (40) @(negedge clk);
		$display("Covered %0d allocate, %0d free, %0d load, %0d unused-op requests, %0d reg writes",
			op_tally[OP_ALLOC], op_tally[OP_FREE], op_tally[OP_LOAD], op_tally[OP_UNUSED],
			reg_writes);
		$display("Outcomes: %0d ok, %0d full, %0d out of range, %0d already free; %0d errors",
			status_tally[STAT_OK], status_tally[STAT_FULL], status_tally[STAT_RANGE],
			status_tally[STAT_ALFREE], errors);
		if (errors == 0 && answers_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
